// File: rtl/srht_pkg.sv
`timescale 1ns / 1ps
// srht_pkg: types, codes and constants shared by the position table modules
// no dependencies

package srht_pkg;

  localparam int TABLE_BITS = 16;
  localparam int SLOT_COUNT = 1 << TABLE_BITS;

  localparam logic [4:0] INDEX_BITS_MIN   = 5'd4;
  localparam logic [4:0] INDEX_BITS_RESET = 5'd16;

  localparam logic signed [16:0] MATE_LIM = 17'sd30744;
  localparam logic signed [16:0] SCORE_MAX = 17'sd32767;
  localparam logic signed [16:0] SCORE_MIN = -17'sd32767;

  localparam logic [1:0] CMD_PROBE = 2'd0;
  localparam logic [1:0] CMD_STORE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] BND_NONE  = 2'd0;
  localparam logic [1:0] BND_EXACT = 2'd1;
  localparam logic [1:0] BND_LOWER = 2'd2;
  localparam logic [1:0] BND_UPPER = 2'd3;

  localparam logic REG_INDEX_BITS = 1'b0;

  typedef struct packed {
    logic [1:0]         command;
    logic [63:0]        key;
    logic [6:0]         ply;
    logic [6:0]         depth;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [15:0] score;
    logic [15:0]        best_move;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [15:0]        entry_move;
    logic               cutoff;
    logic signed [15:0] cutoff_score;
    logic               written;
  } out_t;

  typedef struct packed {
    logic [63:0]        key;
    logic [15:0]        move;
    logic signed [15:0] score;
    logic [6:0]         depth;
    logic [1:0]         bound;
  } slot_t;

  // commands from controller to datapath
  typedef struct packed {
    logic item_load;
    logic rd_en;
    logic sweep_wr;
    logic commit;
    logic out_load;
  } ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic sweep_last;
  } stat_t;

endpackage

// File: rtl/search_result_hash_table.sv
`timescale 1ns / 1ps
// Direct-mapped position table (depth-preferred replacement), one slot per index.
// Input channel in_valid/in_stall/in_data carries probe, store or clear words.
// Result channel out_valid/out_stall/out_data returns one word per input word.
// Config port cfg_*: register index_bits at byte address 0, write and read back.
// Probe and store: one memory read as the word is accepted, then evaluation,
// the optional write back and the result register load. A new word is taken
// only after the previous word's result has been loaded.
// Clear walks all 2^16 slots one per cycle, then loads its result; in_stall
// is high throughout.
// After reset the same zeroing pass runs over all slots with in_stall high;
// configuration writes are taken during it.
// A finished result sits in the output register while the next word is read;
// if out_stall holds that register, the following word waits before its
// result is loaded and no further word is accepted until then.
// Depends on srht_pkg, srht_ctrl, srht_dp, srht_ram.

module search_result_hash_table (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  srht_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output srht_pkg::out_t out_data,
  input  logic           cfg_psel,
  input  logic           cfg_penable,
  input  logic           cfg_pwrite,
  input  logic [2:0]     cfg_paddr,
  input  logic [31:0]    cfg_pwdata,
  output logic [31:0]    cfg_prdata,
  output logic           cfg_pready
);

  srht_pkg::ctl_t  ctl;
  srht_pkg::stat_t stat;

  logic [4:0] index_bits_r;
  logic [4:0] index_bits_nxt;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    index_bits_nxt = index_bits_r;
    if (cfg_wr && cfg_paddr[2] == srht_pkg::REG_INDEX_BITS) begin
      index_bits_nxt = cfg_pwdata[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_bits_r <= srht_pkg::INDEX_BITS_RESET;
    end else begin
      index_bits_r <= index_bits_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == srht_pkg::REG_INDEX_BITS)
                    ? {27'b0, index_bits_r} : 32'd0;

  srht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .ctl        (ctl)
  );

  srht_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .in_data    (in_data),
    .index_bits (index_bits_r),
    .out_data   (out_data)
  );

endmodule

// File: rtl/srht_ram.sv
`timescale 1ns / 1ps
// srht_ram: generic single-port ram with registered read data
// no dependencies

module srht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/srht_dp.sv
`timescale 1ns / 1ps
// srht_dp: item register, slot index, slot memory, sweep counter, probe/store
// evaluation and result register; uses srht_pkg and srht_ram

module srht_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  srht_pkg::ctl_t ctl,
  output srht_pkg::stat_t stat,
  input  srht_pkg::in_t  in_data,
  input  logic [4:0]     index_bits,
  output srht_pkg::out_t out_data
);

  localparam int TB = srht_pkg::TABLE_BITS;

  srht_pkg::in_t   item_r;
  srht_pkg::out_t  out_r;
  srht_pkg::out_t  res;
  srht_pkg::slot_t slot;
  srht_pkg::slot_t new_slot;
  srht_pkg::slot_t wdata;

  logic [TB-1:0] cnt_r;
  logic [TB-1:0] cnt_nxt;
  logic [TB-1:0] mask;
  logic [TB-1:0] ones;
  logic [TB-1:0] in_idx;
  logic [TB-1:0] item_idx;
  logic [TB-1:0] addr;
  logic [4:0]    bits_sat;
  logic          we;

  logic                hit;
  logic                cut;
  logic                replace;
  logic [1:0]          flag;
  logic signed [16:0]  sc_x;
  logic signed [16:0]  ply_x;
  logic signed [16:0]  s_out;
  logic signed [16:0]  in_sc;
  logic signed [16:0]  s_in;
  logic signed [16:0]  s_sat;
  logic signed [16:0]  alpha_x;
  logic signed [16:0]  beta_x;

  // index width clamp and low-bit mask
  always_comb begin
    bits_sat = index_bits;
    if (index_bits < srht_pkg::INDEX_BITS_MIN) begin
      bits_sat = srht_pkg::INDEX_BITS_MIN;
    end else if (index_bits > 5'(TB)) begin
      bits_sat = 5'(TB);
    end
    ones     = '1;
    mask     = ~(ones << bits_sat);
    in_idx   = in_data.key[TB-1:0] & mask;
    item_idx = item_r.key[TB-1:0] & mask;
  end

  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      item_r <= in_data;
    end
    if (ctl.out_load) begin
      out_r <= res;
    end
  end

  // sweep counter wraps to zero at the end of each pass
  assign cnt_nxt = ctl.sweep_wr ? cnt_r + 1'b1 : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign stat.sweep_last = &cnt_r;

  // probe and store evaluation against the slot read when the item was accepted
  always_comb begin
    hit     = (slot.key == item_r.key);
    sc_x    = 17'(slot.score);
    ply_x   = signed'({10'b0, item_r.ply});
    alpha_x = 17'(item_r.alpha);
    beta_x  = 17'(item_r.beta);

    // mate scores move toward zero by ply on probe
    s_out = sc_x;
    if (sc_x >= srht_pkg::MATE_LIM) begin
      s_out = sc_x - ply_x;
    end else if (sc_x <= -srht_pkg::MATE_LIM) begin
      s_out = sc_x + ply_x;
    end

    cut = 1'b0;
    if (hit && item_r.ply != 7'd0 && slot.depth >= item_r.depth) begin
      cut = (slot.bound == srht_pkg::BND_EXACT)
         || (slot.bound == srht_pkg::BND_LOWER && s_out >= beta_x)
         || (slot.bound == srht_pkg::BND_UPPER && s_out <= alpha_x);
    end

    in_sc = 17'(item_r.score);
    if (in_sc <= alpha_x) begin
      flag = srht_pkg::BND_UPPER;
    end else if (in_sc >= beta_x) begin
      flag = srht_pkg::BND_LOWER;
    end else begin
      flag = srht_pkg::BND_EXACT;
    end
    replace = !hit || (item_r.depth >= slot.depth) || (flag == srht_pkg::BND_EXACT);

    // mate scores move away from zero by ply on store, then saturate
    s_in = in_sc;
    if (in_sc >= srht_pkg::MATE_LIM) begin
      s_in = in_sc + ply_x;
    end else if (in_sc <= -srht_pkg::MATE_LIM) begin
      s_in = in_sc - ply_x;
    end
    s_sat = s_in;
    if (s_in > srht_pkg::SCORE_MAX) begin
      s_sat = srht_pkg::SCORE_MAX;
    end else if (s_in < srht_pkg::SCORE_MIN) begin
      s_sat = srht_pkg::SCORE_MIN;
    end

    new_slot.key   = item_r.key;
    new_slot.move  = item_r.best_move;
    new_slot.score = s_sat[15:0];
    new_slot.depth = item_r.depth;
    new_slot.bound = flag;

    res = '0;
    case (item_r.command)
      srht_pkg::CMD_PROBE: begin
        res.hit          = hit;
        res.entry_move   = hit ? slot.move : 16'd0;
        res.cutoff       = cut;
        res.cutoff_score = cut ? s_out[15:0] : 16'sd0;
      end
      srht_pkg::CMD_STORE: begin
        res.written = replace;
      end
      srht_pkg::CMD_CLEAR: begin
        res.written = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // memory port: sweep, new read, or write back at the item's slot
  always_comb begin
    if (ctl.sweep_wr) begin
      addr = cnt_r;
    end else if (ctl.rd_en) begin
      addr = in_idx;
    end else begin
      addr = item_idx;
    end
    we    = ctl.sweep_wr
         || (ctl.commit && item_r.command == srht_pkg::CMD_STORE && replace);
    wdata = ctl.sweep_wr ? '0 : new_slot;
  end

  srht_ram #(
    .WIDTH($bits(srht_pkg::slot_t)),
    .DEPTH(srht_pkg::SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .re    (ctl.rd_en),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (slot)
  );

  assign out_data = out_r;

endmodule

// File: rtl/srht_ctrl.sv
`timescale 1ns / 1ps
// srht_ctrl: sequencing state machine for reset sweep, probe, store and clear
// uses srht_pkg command and status structs

module srht_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_command,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  srht_pkg::stat_t stat,
  output srht_pkg::ctl_t  ctl
);

  localparam logic [1:0] S_INIT  = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_SWEEP = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_INIT: begin
        ctl.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          ctl.item_load = 1'b1;
          if (in_command == srht_pkg::CMD_CLEAR) begin
            state_nxt = S_SWEEP;
          end else begin
            ctl.rd_en = 1'b1;
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        // hold until the result register can take the word
        if (out_free) begin
          ctl.commit   = 1'b1;
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SWEEP: begin
        ctl.sweep_wr = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_LOOK;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
